// ----- rtl/hkr_pkg.sv -----
package hkr_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned ProdW   = 2 * LetterW;
  localparam logic [LetterW-1:0] Modulus = 5'd26;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [ProdW-1:0]   prod_t;

  typedef struct packed {
    letter_t plain_00;
    letter_t plain_01;
    letter_t plain_10;
    letter_t plain_11;
    letter_t cipher_00;
    letter_t cipher_01;
    letter_t cipher_10;
    letter_t cipher_11;
  } hkr_operand_t;

  typedef struct packed {
    letter_t key_00;
    letter_t key_01;
    letter_t key_10;
    letter_t key_11;
    logic    not_invertible;
  } hkr_result_t;

  // fold an input value 0..31 into 0..25
  function automatic letter_t to_letter(input letter_t v);
    return (v >= Modulus) ? letter_t'(v - Modulus) : v;
  endfunction

  // residue mod 26 of a value below 1024: reciprocal estimate, one correction
  function automatic letter_t mod26(input prod_t v);
    logic [15:0] est;
    logic [5:0]  q;
    logic [10:0] r;
    est = 16'(v) * 16'd39;
    q   = est[15:10];
    r   = 11'(v) - 11'(q) * 11'(Modulus);
    return (r[5:0] >= 6'(Modulus)) ? letter_t'(r[5:0] - 6'(Modulus)) : letter_t'(r[5:0]);
  endfunction

  // inverse of a residue mod 26, zero where none exists
  function automatic letter_t unit_inverse(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/hill_key_recovery_2x2_mod26_core.sv -----
// 2x2 hill cipher key recovery mod 26 from one known plaintext/ciphertext pair.
//
// command channel: operand carries the plaintext matrix P and ciphertext
// matrix C. a transaction is taken at a rising edge with start high and busy
// low. busy is always low: the block takes one transaction every cycle.
//
// result channel: result carries the key K = P^-1 * C mod 26 and the
// not_invertible flag; when det(P) has no inverse mod 26 the flag is set and
// the key is zero. done is high for exactly one cycle per result.
//
// pipeline: results come out in order. the eight
// register stages are: input fold, determinant products, determinant residue,
// adjugate scaling products, inverse residues, key products, key product
// residues, and the output sum register; the first loads on the accepting edge.
//
// reset clears every stage valid bit, so no result comes out of a flushed
// transaction. the receiver cannot stall, so the pipeline never holds.
module hill_key_recovery_2x2_mod26_core
  import hkr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  hkr_operand_t operand,
  output logic         done,
  output hkr_result_t  result
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld;

  // stage 0: folded letters
  letter_t s0_p00, s0_p01, s0_p10, s0_p11;
  letter_t s0_c00, s0_c01, s0_c10, s0_c11;
  // stage 1: determinant products
  prod_t   s1_pa, s1_pb;
  letter_t s1_p00, s1_p01, s1_p10, s1_p11;
  letter_t s1_c00, s1_c01, s1_c10, s1_c11;
  // stage 2: determinant
  letter_t s2_det;
  letter_t s2_p00, s2_p01, s2_p10, s2_p11;
  letter_t s2_c00, s2_c01, s2_c10, s2_c11;
  // stage 3: adjugate times inverse
  prod_t   s3_m00, s3_m01, s3_m10, s3_m11;
  logic    s3_sing;
  letter_t s3_c00, s3_c01, s3_c10, s3_c11;
  // stage 4: inverse matrix
  letter_t s4_i00, s4_i01, s4_i10, s4_i11;
  logic    s4_sing;
  letter_t s4_c00, s4_c01, s4_c10, s4_c11;
  // stage 5: key products
  prod_t   s5_k00a, s5_k00b, s5_k01a, s5_k01b;
  prod_t   s5_k10a, s5_k10b, s5_k11a, s5_k11b;
  logic    s5_sing;
  // stage 6: product residues
  letter_t s6_k00a, s6_k00b, s6_k01a, s6_k01b;
  letter_t s6_k10a, s6_k10b, s6_k11a, s6_k11b;
  logic    s6_sing;

  letter_t da, db;
  letter_t dinv;

  assign busy = 1'b0;

  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [LetterW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'(Modulus)) ? letter_t'(s - 6'(Modulus)) : letter_t'(s);
  endfunction

  assign da   = mod26(s1_pa);
  assign db   = mod26(s1_pb);
  assign dinv = unit_inverse(s2_det);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[Stages-2:0], start & ~busy};
      done <= vld[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    s0_p00 <= to_letter(operand.plain_00);
    s0_p01 <= to_letter(operand.plain_01);
    s0_p10 <= to_letter(operand.plain_10);
    s0_p11 <= to_letter(operand.plain_11);
    s0_c00 <= to_letter(operand.cipher_00);
    s0_c01 <= to_letter(operand.cipher_01);
    s0_c10 <= to_letter(operand.cipher_10);
    s0_c11 <= to_letter(operand.cipher_11);

    s1_pa  <= prod_t'(s0_p00) * prod_t'(s0_p11);
    s1_pb  <= prod_t'(s0_p01) * prod_t'(s0_p10);
    s1_p00 <= s0_p00;
    s1_p01 <= s0_p01;
    s1_p10 <= s0_p10;
    s1_p11 <= s0_p11;
    s1_c00 <= s0_c00;
    s1_c01 <= s0_c01;
    s1_c10 <= s0_c10;
    s1_c11 <= s0_c11;

    s2_det <= (da >= db) ? letter_t'(da - db) : letter_t'(da + Modulus - db);
    s2_p00 <= s1_p00;
    s2_p01 <= s1_p01;
    s2_p10 <= s1_p10;
    s2_p11 <= s1_p11;
    s2_c00 <= s1_c00;
    s2_c01 <= s1_c01;
    s2_c10 <= s1_c10;
    s2_c11 <= s1_c11;

    s3_m00  <= prod_t'(s2_p11) * prod_t'(dinv);
    s3_m01  <= prod_t'(Modulus - s2_p01) * prod_t'(dinv);
    s3_m10  <= prod_t'(Modulus - s2_p10) * prod_t'(dinv);
    s3_m11  <= prod_t'(s2_p00) * prod_t'(dinv);
    s3_sing <= (dinv == '0);
    s3_c00  <= s2_c00;
    s3_c01  <= s2_c01;
    s3_c10  <= s2_c10;
    s3_c11  <= s2_c11;

    s4_i00  <= mod26(s3_m00);
    s4_i01  <= mod26(s3_m01);
    s4_i10  <= mod26(s3_m10);
    s4_i11  <= mod26(s3_m11);
    s4_sing <= s3_sing;
    s4_c00  <= s3_c00;
    s4_c01  <= s3_c01;
    s4_c10  <= s3_c10;
    s4_c11  <= s3_c11;

    s5_k00a <= prod_t'(s4_i00) * prod_t'(s4_c00);
    s5_k00b <= prod_t'(s4_i01) * prod_t'(s4_c10);
    s5_k01a <= prod_t'(s4_i00) * prod_t'(s4_c01);
    s5_k01b <= prod_t'(s4_i01) * prod_t'(s4_c11);
    s5_k10a <= prod_t'(s4_i10) * prod_t'(s4_c00);
    s5_k10b <= prod_t'(s4_i11) * prod_t'(s4_c10);
    s5_k11a <= prod_t'(s4_i10) * prod_t'(s4_c01);
    s5_k11b <= prod_t'(s4_i11) * prod_t'(s4_c11);
    s5_sing <= s4_sing;

    s6_k00a <= mod26(s5_k00a);
    s6_k00b <= mod26(s5_k00b);
    s6_k01a <= mod26(s5_k01a);
    s6_k01b <= mod26(s5_k01b);
    s6_k10a <= mod26(s5_k10a);
    s6_k10b <= mod26(s5_k10b);
    s6_k11a <= mod26(s5_k11a);
    s6_k11b <= mod26(s5_k11b);
    s6_sing <= s5_sing;

    // singular plaintext gives a zero key
    result.key_00         <= s6_sing ? '0 : add26(s6_k00a, s6_k00b);
    result.key_01         <= s6_sing ? '0 : add26(s6_k01a, s6_k01b);
    result.key_10         <= s6_sing ? '0 : add26(s6_k10a, s6_k10b);
    result.key_11         <= s6_sing ? '0 : add26(s6_k11a, s6_k11b);
    result.not_invertible <= s6_sing;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Stages + 1))
    else $error("result without a matching transaction");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.not_invertible) |->
      (result.key_00 == '0 && result.key_01 == '0 &&
       result.key_10 == '0 && result.key_11 == '0))
    else $error("singular plaintext with nonzero key");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.key_00 < Modulus && result.key_01 < Modulus &&
              result.key_10 < Modulus && result.key_11 < Modulus))
    else $error("key entry out of range");

  a_det_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (s2_det < Modulus))
    else $error("determinant residue out of range");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule
